// ----- sv/gr121_pkg.sv -----
// Shared constants and types for the 1-2-1 pyramid reduce block.
`default_nettype none
package gr121_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W    = 8;
  localparam int WIDTH_W  = 12;                 // frame_width register
  localparam int HEIGHT_W = 13;                 // frame_height register
  localparam int COL_W    = $clog2(MAX_WIDTH);  // column counter / line address
  localparam int ROW_W    = $clog2(MAX_HEIGHT); // row counter
  localparam int WC_W     = COL_W + 1;          // clamped width, holds MAX_WIDTH
  localparam int HC_W     = ROW_W + 1;          // clamped height, holds MAX_HEIGHT
  localparam int WX_W     = (WC_W > WIDTH_W) ? WC_W : WIDTH_W;
  localparam int HX_W     = (HC_W > HEIGHT_W) ? HC_W : HEIGHT_W;

  localparam int VSUM_W   = PIX_W + 2;          // vertical 1-2-1 column sum
  localparam int FSUM_W   = VSUM_W + 2;         // full 3x3 weighted sum

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = HEIGHT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(480);

  // What an item produces once it reaches the filter stage
  typedef enum logic [2:0] {
    K_NONE   = 3'd0,
    K_SAMPLE = 3'd1,
    K_FIRST  = 3'd2,
    K_FILT   = 3'd3,
    K_LAST   = 3'd4
  } kind_t;

  // Line buffer access issued with each accepted item
  typedef struct packed {
    logic             en;
    logic             wr_older;
    logic [COL_W-1:0] addr;
    logic [PIX_W-1:0] data;
  } lb_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] older;
    logic [PIX_W-1:0] newer;
  } lb_rsp_t;

endpackage
`default_nettype wire

// ----- sv/gr121_if.sv -----
// Valid/ready stream interfaces for input and reduced pixels.
`default_nettype none
interface gr121_in_if;
  logic                       valid;
  logic                       ready;
  logic [gr121_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface gr121_out_if;
  logic                       valid;
  logic                       ready;
  logic [gr121_pkg::PIX_W-1:0] pixel_out;
  logic                       row_end;
  logic                       frame_end;

  modport source (output valid, output pixel_out, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input pixel_out, input row_end, input frame_end,
                  output ready);
endinterface
`default_nettype wire

// ----- sv/gr121_line_buf.sv -----
// Two single-port line memories, read-before-write, with registered read data.
`default_nettype none
module gr121_line_buf (
  input  wire logic               clk,
  input  wire gr121_pkg::lb_req_t req,
  output gr121_pkg::lb_rsp_t      rsp
);

  logic [gr121_pkg::PIX_W-1:0] line_older [gr121_pkg::MAX_WIDTH];
  logic [gr121_pkg::PIX_W-1:0] line_newer [gr121_pkg::MAX_WIDTH];

  // Read returns the old entry when the same address is written
  always_ff @(posedge clk) begin
    if (req.en) begin
      rsp.older <= line_older[req.addr];
      rsp.newer <= line_newer[req.addr];
      if (req.wr_older) begin
        line_older[req.addr] <= req.data;
      end else begin
        line_newer[req.addr] <= req.data;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/gauss_reduce_121_2d_unit.sv -----
// Top level: 3x3 binomial pyramid reduce of an 8-bit raster stream.
//
// in_px carries input pixels in raster order; out_px carries the half-size
// frame ((W+1)/2 by (H+1)/2) in raster order with row_end and frame_end
// flags. The geometry comes from cfg_*: index 0 is frame_width, index 1 is
// frame_height; values are clamped to [2, 2048] and [2, 4096]. Write the
// registers only between items.
// Each accepted pixel reads both line memories at its column and writes
// itself into one of them in the same cycle; the read data arrives in the next
// cycle in the filter stage, which forms the 1-2-1 sums and loads the output
// register. A result passes from the filter stage into the output register
// before it shows on out_px. Throughput is 1 pixel per cycle while out_px
// does not stall, bound by the single port of each line memory. Pixels that
// close no output pixel give no result.
// Reset (rst_n low, synchronous) sets the geometry to 640 x 480 and starts
// a new frame; line contents are not cleared and are used only after being
// written. When out_px stalls, the result holds in the output register and
// one more pixel may enter the filter stage; after that in_px.ready drops.
`default_nettype none
module gauss_reduce_121_2d_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  gr121_in_if.sink                            in_px,
  gr121_out_if.source                         out_px,
  input  wire logic                           cfg_we,
  input  wire logic [gr121_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gr121_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // ---------------- configuration ----------------
  logic [gr121_pkg::WIDTH_W-1:0]  frame_width_r;
  logic [gr121_pkg::HEIGHT_W-1:0] frame_height_r;
  logic [gr121_pkg::WX_W-1:0]     w_raw;
  logic [gr121_pkg::HX_W-1:0]     h_raw;
  logic [gr121_pkg::WC_W-1:0]     w_cl;
  logic [gr121_pkg::HC_W-1:0]     h_cl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= gr121_pkg::WIDTH_RST;
      frame_height_r <= gr121_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gr121_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[gr121_pkg::WIDTH_W-1:0];
        gr121_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_raw = gr121_pkg::WX_W'(frame_width_r);
    h_raw = gr121_pkg::HX_W'(frame_height_r);
    if (w_raw < gr121_pkg::WX_W'(2)) begin
      w_cl = gr121_pkg::WC_W'(2);
    end else if (w_raw > gr121_pkg::WX_W'(gr121_pkg::MAX_WIDTH)) begin
      w_cl = gr121_pkg::WC_W'(gr121_pkg::MAX_WIDTH);
    end else begin
      w_cl = gr121_pkg::WC_W'(w_raw);
    end
    if (h_raw < gr121_pkg::HX_W'(2)) begin
      h_cl = gr121_pkg::HC_W'(2);
    end else if (h_raw > gr121_pkg::HX_W'(gr121_pkg::MAX_HEIGHT)) begin
      h_cl = gr121_pkg::HC_W'(gr121_pkg::MAX_HEIGHT);
    end else begin
      h_cl = gr121_pkg::HC_W'(h_raw);
    end
  end

  // ---------------- handshake ----------------
  logic out_valid_r;
  logic s1_valid_r;
  logic out_free;
  logic s1_adv;
  logic accept;

  assign out_free     = !out_valid_r || out_px.ready;
  assign s1_adv       = s1_valid_r && out_free;
  assign in_px.ready  = !s1_valid_r || out_free;
  assign accept       = in_px.valid && in_px.ready;

  // ---------------- stage 0: position and line access ----------------
  logic [gr121_pkg::COL_W-1:0] col_r, col_nxt;
  logic [gr121_pkg::ROW_W-1:0] row_r, row_nxt;
  logic                        last_col;
  logic                        last_row;
  logic                        sampled_row;
  logic                        filt_row;
  gr121_pkg::kind_t            kind;
  logic                        rend;
  logic                        fend;
  gr121_pkg::lb_req_t          lb_req;
  gr121_pkg::lb_rsp_t          lb_rsp;

  always_comb begin
    last_col    = (gr121_pkg::WC_W'(col_r) + gr121_pkg::WC_W'(1)) >= w_cl;
    last_row    = (gr121_pkg::HC_W'(row_r) + gr121_pkg::HC_W'(1)) >= h_cl;
    sampled_row = (row_r == '0) || (!row_r[0] && last_row);
    filt_row    = row_r[0] && (row_r >= gr121_pkg::ROW_W'(3));
    kind        = gr121_pkg::K_NONE;
    rend        = 1'b0;
    if (sampled_row) begin
      if (!col_r[0]) begin
        kind = gr121_pkg::K_SAMPLE;
        rend = (gr121_pkg::WC_W'(col_r) + gr121_pkg::WC_W'(2)) >= w_cl;
      end
    end else if (filt_row) begin
      if (col_r == gr121_pkg::COL_W'(1)) begin
        kind = gr121_pkg::K_FIRST;
      end else if (col_r[0]) begin
        kind = gr121_pkg::K_FILT;
      end else if (last_col) begin
        kind = gr121_pkg::K_LAST;
      end
      rend = last_col && (kind != gr121_pkg::K_NONE);
    end
    fend = rend && (last_row || (h_cl == gr121_pkg::HC_W'(2)));

    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + gr121_pkg::ROW_W'(1);
    end else begin
      col_nxt = col_r + gr121_pkg::COL_W'(1);
      row_nxt = row_r;
    end

    lb_req.en       = accept;
    lb_req.wr_older = row_r[0];
    lb_req.addr     = col_r;
    lb_req.data     = in_px.pixel_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  gr121_line_buf u_line_buf (
    .clk (clk),
    .req (lb_req),
    .rsp (lb_rsp)
  );

  // ---------------- stage 1: filter ----------------
  logic [gr121_pkg::PIX_W-1:0]  s1_pix_r;
  gr121_pkg::kind_t             s1_kind_r;
  logic                         s1_rend_r;
  logic                         s1_fend_r;
  logic                         s1_col0_r;
  logic [gr121_pkg::PIX_W-1:0]  newer0_r;
  logic [gr121_pkg::VSUM_W-1:0] col_sum_a_r;
  logic [gr121_pkg::VSUM_W-1:0] col_sum_b_r;
  logic [gr121_pkg::VSUM_W-1:0] vsum;
  logic [gr121_pkg::FSUM_W-1:0] fsum;
  logic [gr121_pkg::PIX_W-1:0]  res_pix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= in_px.pixel_in;
      s1_kind_r <= kind;
      s1_rend_r <= rend;
      s1_fend_r <= fend;
      s1_col0_r <= (col_r == '0);
    end
  end

  always_comb begin
    vsum = gr121_pkg::VSUM_W'(lb_rsp.older) + {1'b0, lb_rsp.newer, 1'b0}
         + gr121_pkg::VSUM_W'(s1_pix_r);
    fsum = gr121_pkg::FSUM_W'(col_sum_b_r) + {1'b0, col_sum_a_r, 1'b0}
         + gr121_pkg::FSUM_W'(vsum) + gr121_pkg::FSUM_W'(8);
    case (s1_kind_r)
      gr121_pkg::K_SAMPLE: res_pix = s1_pix_r;
      gr121_pkg::K_FIRST:  res_pix = newer0_r;
      gr121_pkg::K_FILT:   res_pix = fsum[gr121_pkg::FSUM_W-1:4];
      gr121_pkg::K_LAST:   res_pix = lb_rsp.newer;
      default:             res_pix = s1_pix_r;
    endcase
  end

  // Column sums advance with every item; first-column pass-through is the
  // newer line entry read at column zero of the same row.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_sum_a_r <= '0;
      col_sum_b_r <= '0;
    end else if (s1_adv) begin
      col_sum_b_r <= col_sum_a_r;
      col_sum_a_r <= vsum;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_col0_r) begin
      newer0_r <= lb_rsp.newer;
    end
  end

  // ---------------- output register ----------------
  logic [gr121_pkg::PIX_W-1:0] out_pix_r;
  logic                        out_rend_r;
  logic                        out_fend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= (s1_kind_r != gr121_pkg::K_NONE);
    end else if (out_px.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pix_r  <= res_pix;
      out_rend_r <= s1_rend_r;
      out_fend_r <= s1_fend_r;
    end
  end

  assign out_px.valid     = out_valid_r;
  assign out_px.pixel_out = out_pix_r;
  assign out_px.row_end   = out_rend_r;
  assign out_px.frame_end = out_fend_r;

`ifndef SYNTH
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted item did not reach the filter stage");

  a_s1_holds_read: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(s1_kind_r)
                                   && $stable(lb_rsp) && $stable(s1_pix_r)))
    else $error("filter stage changed while stalled");

  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_px.ready)
    else $error("input stalled with an empty output register");

  a_fend_has_rend: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_fend_r) |-> (s1_rend_r && s1_kind_r != gr121_pkg::K_NONE))
    else $error("frame end without row end");
`endif

endmodule
`default_nettype wire
